[rtl/deq_pkg.sv]
// shared constants, types and ring arithmetic for the double-ended queue
package deq_pkg;

  localparam int unsigned Depth     = 16;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned PtrW      = $clog2(Depth);
  localparam int unsigned CntW      = $clog2(Depth + 1);

  localparam int unsigned OpW       = 3;
  localparam int unsigned PushW     = 32;
  localparam int unsigned PopW      = 32;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned CountOutW = 5;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 40;

  typedef logic [PtrW-1:0]      ptr_t;
  typedef logic [CntW-1:0]      cnt_t;
  typedef logic [DataWidth-1:0] word_t;
  typedef logic [OpW-1:0]       op_t;
  typedef logic [StatusW-1:0]   status_t;

  localparam op_t OpPushFront = 3'd0;
  localparam op_t OpPushBack  = 3'd1;
  localparam op_t OpPopFront  = 3'd2;
  localparam op_t OpPopBack   = 3'd3;
  localparam op_t OpClear     = 3'd4;

  localparam status_t StOk    = 2'd0;
  localparam status_t StEmpty = 2'd1;
  localparam status_t StFull  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic capture;  // take the input beat and start the slot read
    logic execute;  // apply the operation and load the result register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;  // result register can take a new result this cycle
  } dp_sts_t;

  // base + off wrapped into the ring, off below Depth
  function automatic ptr_t ring_add(input ptr_t base, input cnt_t off);
    logic [CntW:0] sum;
    sum = {1'b0, CntW'(base)} + {1'b0, off};
    if (sum >= (CntW + 1)'(Depth)) begin
      sum = sum - (CntW + 1)'(Depth);
    end
    return PtrW'(sum);
  endfunction

  // one slot toward the front, wrapping below zero
  function automatic ptr_t ring_dec(input ptr_t base);
    ptr_t res;
    if (base == '0) begin
      res = PtrW'(Depth - 1);
    end else begin
      res = base - ptr_t'(1);
    end
    return res;
  endfunction

endpackage

[rtl/deq_ctrl.sv]
// sequencing of one operation: accept a beat, then commit it once the result register is free
module deq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  deq_pkg::dp_sts_t  sts_i,
  output deq_pkg::dp_cmd_t  cmd_o
);
  import deq_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic state_q, state_d;

  assign in_ready_o    = (state_q == StIdle);
  assign cmd_o.capture = in_valid_i && (state_q == StIdle);
  assign cmd_o.execute = (state_q == StExec) && sts_i.out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StExec;
        end
      end
      StExec: begin
        if (sts_i.out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/deq_datapath.sv]
// slot memory, head and count registers, operation decode and result register
module deq_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  deq_pkg::dp_cmd_t                  cmd_i,
  output deq_pkg::dp_sts_t                  sts_o,
  input  deq_pkg::op_t                      opcode_i,
  input  logic signed [deq_pkg::PushW-1:0]  push_value_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic signed [deq_pkg::PopW-1:0]   pop_value_o,
  output deq_pkg::status_t                  status_o,
  output logic [deq_pkg::CountOutW-1:0]     count_after_o
);
  import deq_pkg::*;

  word_t slots_q [Depth];

  ptr_t    head_q, head_d;
  cnt_t    count_q, count_d;
  op_t     op_q;
  word_t   word_q;
  word_t   rd_data_q;
  ptr_t    rd_addr;
  ptr_t    wr_addr;
  logic    wr_en;
  logic    full;
  logic    empty;
  word_t   popped;
  status_t status;

  logic                 out_valid_q, out_valid_d;
  logic [PopW-1:0]      pop_q;
  status_t              status_q;
  logic [CountOutW-1:0] count_out_q;

  assign full  = (count_q == cnt_t'(Depth));
  assign empty = (count_q == '0);

  // the slot a pop needs is known from head and count at the accepting edge
  always_comb begin
    rd_addr = head_q;
    if (opcode_i == OpPopBack && !empty) begin
      rd_addr = ring_add(head_q, count_q - cnt_t'(1));
    end
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    wr_en   = 1'b0;
    wr_addr = head_q;
    popped  = '0;
    status  = StOk;
    unique case (op_q)
      OpPushFront: begin
        if (full) begin
          status = StFull;
        end else begin
          head_d  = ring_dec(head_q);
          wr_addr = ring_dec(head_q);
          wr_en   = 1'b1;
          count_d = count_q + cnt_t'(1);
        end
      end
      OpPushBack: begin
        if (full) begin
          status = StFull;
        end else begin
          wr_addr = ring_add(head_q, count_q);
          wr_en   = 1'b1;
          count_d = count_q + cnt_t'(1);
        end
      end
      OpPopFront: begin
        if (empty) begin
          status = StEmpty;
        end else begin
          popped  = rd_data_q;
          head_d  = ring_add(head_q, cnt_t'(1));
          count_d = count_q - cnt_t'(1);
        end
      end
      OpPopBack: begin
        if (empty) begin
          status = StEmpty;
        end else begin
          popped  = rd_data_q;
          count_d = count_q - cnt_t'(1);
        end
      end
      OpClear: begin
        head_d  = '0;
        count_d = '0;
      end
      default: ;
    endcase
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.execute) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rd_data_q <= slots_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute && wr_en) begin
      slots_q[wr_addr] <= word_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= opcode_i;
      word_q <= DataWidth'(push_value_i);
    end
    if (cmd_i.execute) begin
      pop_q       <= PopW'(popped);
      status_q    <= status;
      count_out_q <= CountOutW'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_i.execute) begin
        head_q  <= head_d;
        count_q <= count_d;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pop_value_o   = pop_q;
  assign status_o      = status_q;
  assign count_after_o = count_out_q;

endmodule

[rtl/double_ended_queue.sv]
// top level of the double-ended queue: stream ports, controller and datapath
//
// Input stream (s_axis): each beat carries an opcode (push front, push back,
// pop front, pop back, clear) and a signed 32-bit push value. Output stream
// (m_axis): exactly one beat per input beat, in order, with the popped word,
// a status (ok, pop on empty, push on full dropped) and the entry count after
// the operation. The queue holds up to 16 words in a ring of slots.
// An item is handled in order: the accepting edge starts the registered slot read
// of the single-read-port memory, and the edge at which the output register is
// free commits the operation and loads the output register; no new beat is
// taken before the previous one has been committed.
// A new beat is accepted while the previous result still waits in the output
// register; if the receiver holds m_axis_tready_i low, the following beat is
// held in the datapath and tready drops until the output register frees up.
// Reset empties the queue (head and count to zero) and clears m_axis_tvalid_o;
// no clearing pass is needed.
module double_ended_queue (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [2:0] opcode, [34:3] push_value, [39:35] zero
  input  logic [deq_pkg::InDataW-1:0]     s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [31:0] pop_value, [33:32] status, [38:34] count_after, [39] zero
  output logic [deq_pkg::OutDataW-1:0]    m_axis_tdata_o
);
  import deq_pkg::*;

  dp_cmd_t              cmd;
  dp_sts_t              sts;
  logic signed [PopW-1:0] pop_value;
  status_t              status;
  logic [CountOutW-1:0] count_after;

  deq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  deq_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .opcode_i      (s_axis_tdata_i[OpW-1:0]),
    .push_value_i  (s_axis_tdata_i[OpW+PushW-1:OpW]),
    .out_ready_i   (m_axis_tready_i),
    .out_valid_o   (m_axis_tvalid_o),
    .pop_value_o   (pop_value),
    .status_o      (status),
    .count_after_o (count_after)
  );

  assign m_axis_tdata_o = {{(OutDataW - PopW - StatusW - CountOutW){1'b0}},
                           count_after, status, pop_value};

  // a beat taken leaves the input closed for the commit cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted on two consecutive cycles");

  // an empty report always comes with an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && status == StEmpty |-> count_after == '0)
    else $error("empty status with nonzero count");

  // a dropped push only happens on a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && status == StFull |-> count_after == CountOutW'(Depth))
    else $error("full status with count below depth");

  // count never runs past the ring size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> count_after <= CountOutW'(Depth))
    else $error("count above depth");

endmodule
